/* rtl/trp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Telnet receive parser package
// Shared types, byte codes and event codes of the telnet receive parser.
// ----------------------------------------------------------------------------
package trp_pkg;

  // Telnet command and control bytes.
  localparam logic [7:0] BYTE_IAC  = 8'd255;
  localparam logic [7:0] BYTE_DONT = 8'd254;
  localparam logic [7:0] BYTE_WILL = 8'd251;
  localparam logic [7:0] BYTE_SB   = 8'd250;
  localparam logic [7:0] BYTE_SE   = 8'd240;
  localparam logic [7:0] BYTE_CR   = 8'd13;
  localparam logic [7:0] BYTE_LF   = 8'd10;
  localparam logic [7:0] BYTE_NUL  = 8'd0;

  // Option tag that means no subnegotiation is open.
  localparam logic [7:0] OPTION_NONE = 8'd255;

  // Event kinds on the output channel.
  localparam logic [2:0] EV_TEXT     = 3'd0;
  localparam logic [2:0] EV_WILL     = 3'd1;
  localparam logic [2:0] EV_DONT     = 3'd4;
  localparam logic [2:0] EV_SUB_DATA = 3'd5;
  localparam logic [2:0] EV_SUB_END  = 3'd6;

  // Pending negotiation command; zero means none.
  localparam logic [2:0] CMD_NONE = 3'd0;

  typedef enum logic [1:0] {
    PH_NORMAL = 2'd0,
    PH_IAC    = 2'd1,
    PH_OPT    = 2'd2,
    PH_SBOPT  = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    NL_NONE   = 2'd0,
    NL_AFT_CR = 2'd1,
    NL_AFT_LF = 2'd2
  } newline_t;

  // Parser state carried from one byte to the next.
  typedef struct packed {
    phase_t     phase;
    logic [2:0] pending_command;
    newline_t   newline_swallow;
    logic       in_subnegotiation;
    logic [7:0] current_option;
  } parse_state_t;

  // One result event.
  typedef struct packed {
    logic [2:0] event_kind;
    logic [7:0] event_value;
    logic [7:0] sub_option;
  } event_t;

endpackage

/* rtl/trp_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Telnet receive parser channels
// Valid/ready channels for received bytes and for parsed events.
// ----------------------------------------------------------------------------
interface trp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface trp_event_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_kind;
  logic [7:0] event_value;
  logic [7:0] sub_option;

  modport source (output valid, output event_kind, output event_value,
                  output sub_option, input ready);
  modport sink   (input valid, input event_kind, input event_value,
                  input sub_option, output ready);
endinterface

/* rtl/trp_decode.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Telnet receive parser byte decoder
// Combinational next-state and event logic for one received byte.
// ----------------------------------------------------------------------------
module trp_decode
  import trp_pkg::*;
(
  input  parse_state_t state,
  input  logic [7:0]   rx_byte,
  output parse_state_t state_next,
  output logic         emit,
  output event_t       event_data
);

  always_comb begin
    state_next                 = state;
    state_next.phase           = PH_NORMAL;
    state_next.newline_swallow = NL_NONE;
    emit                       = 1'b0;
    event_data.event_kind      = EV_TEXT;
    event_data.event_value     = rx_byte;
    event_data.sub_option      = OPTION_NONE;

    unique case (state.phase)
      // Command byte after IAC.
      PH_IAC: begin
        if (rx_byte == BYTE_IAC) begin
          emit = 1'b1;
          if (state.in_subnegotiation) begin
            event_data.event_kind = EV_SUB_DATA;
            event_data.sub_option = state.current_option;
          end
        end else if (rx_byte >= BYTE_WILL && rx_byte <= BYTE_DONT) begin
          state_next.pending_command = 3'(rx_byte - BYTE_WILL) + 3'd1;
          state_next.phase           = PH_OPT;
        end else if (rx_byte == BYTE_SB) begin
          state_next.phase = PH_SBOPT;
        end else if (rx_byte == BYTE_SE) begin
          emit                         = 1'b1;
          event_data.event_kind        = EV_SUB_END;
          event_data.event_value       = 8'd0;
          event_data.sub_option        = state.in_subnegotiation ?
                                         state.current_option : OPTION_NONE;
          state_next.in_subnegotiation = 1'b0;
          state_next.current_option    = OPTION_NONE;
        end
      end

      // Option byte of a negotiation command.
      PH_OPT: begin
        if (state.pending_command >= EV_WILL && state.pending_command <= EV_DONT) begin
          emit                  = 1'b1;
          event_data.event_kind = state.pending_command;
        end
      end

      // Option byte that opens a subnegotiation.
      PH_SBOPT: begin
        state_next.in_subnegotiation = 1'b1;
        state_next.current_option    = rx_byte;
      end

      // Plain data, start of an IAC command, subnegotiation payload, NUL dropping or newline folding.
      default: begin
        if (rx_byte == BYTE_IAC) begin
          state_next.phase = PH_IAC;
        end else if (state.in_subnegotiation) begin
          emit                  = 1'b1;
          event_data.event_kind = EV_SUB_DATA;
          event_data.sub_option = state.current_option;
        end else if (state.newline_swallow == NL_AFT_CR &&
                     (rx_byte == BYTE_LF || rx_byte == BYTE_NUL)) begin
          emit = 1'b0;
        end else if (state.newline_swallow == NL_AFT_LF && rx_byte == BYTE_CR) begin
          emit = 1'b0;
        end else if (rx_byte == BYTE_NUL) begin
          emit = 1'b0;
        end else if (rx_byte == BYTE_CR) begin
          emit                       = 1'b1;
          event_data.event_value     = BYTE_LF;
          state_next.newline_swallow = NL_AFT_CR;
        end else if (rx_byte == BYTE_LF) begin
          emit                       = 1'b1;
          state_next.newline_swallow = NL_AFT_LF;
        end else begin
          emit = 1'b1;
        end
      end
    endcase
  end

endmodule

/* rtl/telnet_receive_parser_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Telnet receive parser
// Turns a received telnet byte stream into text, negotiation and
// subnegotiation events.
// ----------------------------------------------------------------------------
// The parser takes one byte per cycle into an input register; the next
// cycle decodes it against the parser state and, when the byte yields an
// event, loads the event into the output register. One byte per cycle is
// sustained as long as the event sink keeps up; the output register alone
// sets the rate, since a byte that yields no event leaves its stage even
// while an event waits. Bytes that are only part of a command, dropped NULs
// and swallowed newline followers produce no event.
module telnet_receive_parser_unit
  import trp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  trp_byte_if.sink    rx,
  trp_event_if.source events
);

  logic         stage_valid;
  logic [7:0]   stage_byte;
  parse_state_t state;
  parse_state_t state_next;
  logic         emit;
  event_t       event_data;
  logic         out_valid;
  event_t       out_data;
  logic         stage_advance;
  logic         out_load;

  trp_decode u_decode (
    .state      (state),
    .rx_byte    (stage_byte),
    .state_next (state_next),
    .emit       (emit),
    .event_data (event_data)
  );

  // A decoded byte leaves its stage unless its event would hit a full output.
  assign stage_advance = stage_valid && (!emit || !out_valid || events.ready);
  assign out_load      = stage_advance && emit;
  assign rx.ready      = !stage_valid || stage_advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (rx.ready) begin
      stage_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      stage_byte <= rx.rx_byte;
    end
  end

  // Parser state, updated as each byte is decoded.
  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase             <= PH_NORMAL;
      state.pending_command   <= CMD_NONE;
      state.newline_swallow   <= NL_NONE;
      state.in_subnegotiation <= 1'b0;
      state.current_option    <= OPTION_NONE;
    end else if (stage_advance) begin
      state <= state_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (events.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= event_data;
    end
  end

  assign events.valid       = out_valid;
  assign events.event_kind  = out_data.event_kind;
  assign events.event_value = out_data.event_value;
  assign events.sub_option  = out_data.sub_option;

endmodule
